// ===== rtl/rcm_pkg.sv =====
// Shared constants for the reverse Cuthill-McKee ordering block.
// Holds action codes, result kinds, field widths and register addresses.
// No dependencies.
`default_nettype none

package rcm_pkg;

    localparam int DEF_MAX_VERTICES    = 1024;
    localparam int DEF_MAX_ADJ_ENTRIES = 8192;
    localparam int DEF_REF_BITS        = 20;

    localparam int ACTION_W  = 3;
    localparam int NBR_W     = 10;
    localparam int SEL_W     = 11;
    localparam int POS_W     = 10;
    localparam int OVERT_W   = 10;
    localparam int RESTART_W = 10;
    localparam int PADDR_W   = 3;

    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD_VERT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ADD_NBR  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RUN      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ     = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [PADDR_W-1:0] ADDR_START_VERTEX = 3'd0;

    localparam logic signed [SEL_W-1:0] START_NONE = -11'sd1;

endpackage

`default_nettype wire

// ===== rtl/rcm_cfg.sv =====
// Configuration register file of the ordering block, behind an APB-style port.
// Holds the default start vertex. Depends on rcm_pkg.
`default_nettype none

module rcm_cfg
    import rcm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [PADDR_W-1:0]      paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    output logic                         pready,
    output logic signed [SEL_W-1:0]      start_vertex
);

    logic signed [SEL_W-1:0] start_vertex_reg;
    logic                    wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_vertex_reg <= START_NONE;
        end
        else if (wr_en && paddr == ADDR_START_VERTEX)
        begin
            start_vertex_reg <= SEL_W'(pwdata);
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_START_VERTEX: prdata = 32'(start_vertex_reg);
            default:           prdata = '0;
        endcase
    end

    assign start_vertex = start_vertex_reg;

endmodule

`default_nettype wire

// ===== rtl/reverse_cuthill_mckee_order.sv =====
// Top level of the reverse Cuthill-McKee ordering engine: graph memories,
// breadth-first walk sequencer and read-back. Depends on rcm_pkg and rcm_cfg.
//
// Usage. An item is taken when start is high and busy is low. Action codes:
// clear graph, add vertex, add neighbor, run ordering, read position.
// Load items (clear, add vertex, add neighbor) finish in the accept cycle
// and give no result; busy stays low. A read passes the reference fetch
// state and the read output flag before its done beat, with busy high in
// between. A run first clears the visit marks over all loaded vertices,
// then walks the graph with one shared memory sequencer: per placed vertex
// it reads the adjacency bounds and checks each neighbor's visit mark, and
// when the queue runs dry it scans for an unvisited vertex to restart from.
// Each result is shown for one cycle with done high and cannot be held off
// by the receiver. The start_vertex register is to be written over the APB
// port while the block is idle; the block itself does not enforce this.
// After reset the graph is empty, no order is valid and start_vertex is -1.
`default_nettype none

module reverse_cuthill_mckee_order
    import rcm_pkg::*;
#(
    parameter int MAX_VERTICES    = DEF_MAX_VERTICES,
    parameter int MAX_ADJ_ENTRIES = DEF_MAX_ADJ_ENTRIES,
    parameter int REF_BITS        = DEF_REF_BITS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [PADDR_W-1:0]      paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    output logic                         pready,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [ACTION_W-1:0]     action,
    input  wire logic [REF_BITS-1:0]     vertex_ref,
    input  wire logic [NBR_W-1:0]        neighbor_id,
    input  wire logic signed [SEL_W-1:0] start_choice,
    input  wire logic [POS_W-1:0]        position,
    output logic                         done,
    output logic                         kind,
    output logic [OVERT_W-1:0]           ordered_vertex,
    output logic [REF_BITS-1:0]          ordered_ref,
    output logic                         start_fell_back,
    output logic [RESTART_W-1:0]         restarts
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CW = NW + 1;
    localparam int AW = $clog2(MAX_ADJ_ENTRIES);
    localparam int EW = $clog2(MAX_ADJ_ENTRIES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_INIT  = 4'd2;
    localparam logic [3:0] S_LOOP  = 4'd3;
    localparam logic [3:0] S_ORD   = 4'd4;
    localparam logic [3:0] S_ADJA  = 4'd5;
    localparam logic [3:0] S_ADJB  = 4'd6;
    localparam logic [3:0] S_ADJC  = 4'd7;
    localparam logic [3:0] S_NBR   = 4'd8;
    localparam logic [3:0] S_VIS   = 4'd9;
    localparam logic [3:0] S_CHK   = 4'd10;
    localparam logic [3:0] S_NEXT  = 4'd11;
    localparam logic [3:0] S_SCAN  = 4'd12;
    localparam logic [3:0] S_SCHK  = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;
    localparam logic [3:0] S_RREF  = 4'd15;

    logic signed [SEL_W-1:0] start_vertex;

    rcm_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start_vertex (start_vertex)
    );

    // Control and walk registers
    logic [3:0]            state_reg, state_next;
    logic [NW-1:0]         vcount_reg, vcount_next;
    logic [EW-1:0]         edge_count_reg, edge_count_next;
    logic [NW-1:0]         order_len_reg, order_len_next;
    logic                  fell_reg, fell_next;
    logic [RESTART_W-1:0]  rst_cnt_reg, rst_cnt_next;
    logic signed [CW-1:0]  cur_reg, cur_next;
    logic signed [CW-1:0]  nxt_reg, nxt_next;
    logic [NW-1:0]         scan_reg, scan_next;
    logic [VW-1:0]         root_reg, root_next;
    logic [VW-1:0]         v_reg, v_next;
    logic [EW-1:0]         i_reg, i_next;
    logic [EW-1:0]         b_reg, b_next;
    logic [VW-1:0]         w_reg, w_next;
    logic                  hit_reg, hit_next;
    logic                  done_reg, done_next;
    logic                  kind_reg, kind_next;
    logic [OVERT_W-1:0]    overt_reg, overt_next;
    logic [REF_BITS-1:0]   oref_reg, oref_next;

    // Memories
    logic [REF_BITS-1:0] ref_mem   [MAX_VERTICES];
    logic [EW-1:0]       adj_mem   [MAX_VERTICES];
    logic [NBR_W-1:0]    nbr_mem   [MAX_ADJ_ENTRIES];
    logic                vis_mem   [MAX_VERTICES];
    logic [VW-1:0]       ord_mem   [MAX_VERTICES];

    logic [REF_BITS-1:0] ref_rd_reg;
    logic [EW-1:0]       adj_rd_reg;
    logic [NBR_W-1:0]    nbr_rd_reg;
    logic                vis_rd_reg;
    logic [VW-1:0]       ord_rd_reg;

    logic [VW-1:0] ref_ra, adj_ra, vis_ra, ord_ra;
    logic [AW-1:0] nbr_ra;
    logic          ref_we, adj_we, nbr_we, vis_we, ord_we;
    logic [VW-1:0] ref_wa, adj_wa, vis_wa, ord_wa;
    logic [AW-1:0] nbr_wa;
    logic          vis_wd;
    logic [VW-1:0] ord_wd;

    always_ff @(posedge clk)
    begin
        if (ref_we) ref_mem[ref_wa] <= vertex_ref;
        ref_rd_reg <= ref_mem[ref_ra];
    end

    always_ff @(posedge clk)
    begin
        if (adj_we) adj_mem[adj_wa] <= edge_count_reg;
        adj_rd_reg <= adj_mem[adj_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nbr_we) nbr_mem[nbr_wa] <= neighbor_id;
        nbr_rd_reg <= nbr_mem[nbr_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we) vis_mem[vis_wa] <= vis_wd;
        vis_rd_reg <= vis_mem[vis_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we) ord_mem[ord_wa] <= ord_wd;
        ord_rd_reg <= ord_mem[ord_ra];
    end

    logic                  accept;
    logic signed [SEL_W-1:0] req;
    logic signed [31:0]    req32, n32;
    logic                  req_bad;
    logic signed [CW-1:0]  n_s, cur_dec;
    logic [31:0]           w32;

    assign accept  = start && !busy;
    assign req     = (start_choice == START_NONE) ? start_vertex : start_choice;
    assign req32   = 32'(req);
    assign n32     = signed'(32'(vcount_reg));
    assign req_bad = (req != START_NONE) && (req32 < 0 || req32 >= n32);
    assign n_s     = signed'(CW'(vcount_reg));
    assign cur_dec = cur_reg - CW'(1);
    assign w32     = 32'(nbr_rd_reg);

    always_comb
    begin
        state_next      = state_reg;
        vcount_next     = vcount_reg;
        edge_count_next = edge_count_reg;
        order_len_next  = order_len_reg;
        fell_next       = fell_reg;
        rst_cnt_next    = rst_cnt_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        scan_next       = scan_reg;
        root_next       = root_reg;
        v_next          = v_reg;
        i_next          = i_reg;
        b_next          = b_reg;
        w_next          = w_reg;
        hit_next        = hit_reg;
        done_next       = 1'b0;
        kind_next       = kind_reg;
        overt_next      = overt_reg;
        oref_next       = oref_reg;

        ref_we = 1'b0; ref_wa = VW'(vcount_reg); ref_ra = ord_rd_reg;
        adj_we = 1'b0; adj_wa = VW'(vcount_reg); adj_ra = v_reg;
        nbr_we = 1'b0; nbr_wa = AW'(edge_count_reg); nbr_ra = AW'(i_reg);
        vis_we = 1'b0; vis_wa = VW'(scan_reg); vis_wd = 1'b0;
        vis_ra = VW'(scan_reg);
        ord_we = 1'b0; ord_wa = VW'(cur_reg); ord_wd = root_reg;
        ord_ra = VW'(cur_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_CLEAR:
                        begin
                            vcount_next     = '0;
                            edge_count_next = '0;
                            order_len_next  = '0;
                        end
                        ACT_ADD_VERT:
                        begin
                            if (32'(vcount_reg) < 32'(MAX_VERTICES))
                            begin
                                ref_we      = 1'b1;
                                adj_we      = 1'b1;
                                vcount_next = vcount_reg + NW'(1);
                            end
                        end
                        ACT_ADD_NBR:
                        begin
                            if (vcount_reg != '0 &&
                                32'(edge_count_reg) < 32'(MAX_ADJ_ENTRIES))
                            begin
                                nbr_we          = 1'b1;
                                edge_count_next = edge_count_reg + EW'(1);
                            end
                        end
                        ACT_RUN:
                        begin
                            rst_cnt_next   = '0;
                            order_len_next = '0;
                            if (vcount_reg == '0)
                            begin
                                fell_next = 1'b0;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                fell_next  = req_bad;
                                root_next  = (req_bad || req == START_NONE) ?
                                             '0 : VW'(req32);
                                cur_next   = n_s - CW'(1);
                                nxt_next   = n_s - CW'(2);
                                scan_next  = '0;
                                state_next = S_CLR;
                            end
                        end
                        ACT_READ:
                        begin
                            hit_next   = 32'(position) < 32'(order_len_reg);
                            ord_ra     = VW'(position);
                            state_next = S_RREF;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                vis_we = 1'b1;
                vis_wd = 1'b0;
                if (scan_reg + NW'(1) == vcount_reg)
                begin
                    scan_next  = '0;
                    state_next = S_INIT;
                end
                else
                begin
                    scan_next = scan_reg + NW'(1);
                end
            end
            S_INIT:
            begin
                ord_we     = 1'b1;
                vis_we     = 1'b1;
                vis_wa     = root_reg;
                vis_wd     = 1'b1;
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                state_next = (nxt_reg >= 0) ? S_ORD : S_FIN;
            end
            S_ORD:
            begin
                state_next = S_ADJA;
            end
            S_ADJA:
            begin
                v_next     = ord_rd_reg;
                adj_ra     = ord_rd_reg;
                state_next = S_ADJB;
            end
            S_ADJB:
            begin
                i_next     = adj_rd_reg;
                adj_ra     = v_reg + VW'(1);
                state_next = S_ADJC;
            end
            S_ADJC:
            begin
                b_next     = (NW'(v_reg) + NW'(1) == vcount_reg) ?
                             edge_count_reg : adj_rd_reg;
                state_next = S_NBR;
            end
            S_NBR:
            begin
                state_next = (i_reg < b_reg && nxt_reg >= 0) ? S_VIS : S_NEXT;
            end
            S_VIS:
            begin
                w_next = VW'(nbr_rd_reg);
                vis_ra = VW'(nbr_rd_reg);
                if (w32 < 32'(vcount_reg))
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    i_next     = i_reg + EW'(1);
                    state_next = S_NBR;
                end
            end
            S_CHK:
            begin
                if (!vis_rd_reg)
                begin
                    vis_we   = 1'b1;
                    vis_wa   = w_reg;
                    vis_wd   = 1'b1;
                    ord_we   = 1'b1;
                    ord_wa   = VW'(nxt_reg);
                    ord_wd   = w_reg;
                    nxt_next = nxt_reg - CW'(1);
                end
                i_next     = i_reg + EW'(1);
                state_next = S_NBR;
            end
            S_NEXT:
            begin
                cur_next   = cur_dec;
                state_next = (cur_dec == nxt_reg && cur_dec >= 0) ? S_SCAN : S_LOOP;
            end
            S_SCAN:
            begin
                state_next = (scan_reg < vcount_reg) ? S_SCHK : S_FIN;
            end
            S_SCHK:
            begin
                if (vis_rd_reg)
                begin
                    scan_next  = scan_reg + NW'(1);
                    state_next = S_SCAN;
                end
                else
                begin
                    vis_we       = 1'b1;
                    vis_wd       = 1'b1;
                    ord_we       = 1'b1;
                    ord_wd       = VW'(scan_reg);
                    nxt_next     = nxt_reg - CW'(1);
                    rst_cnt_next = rst_cnt_reg + RESTART_W'(1);
                    state_next   = S_LOOP;
                end
            end
            S_FIN:
            begin
                order_len_next = vcount_reg;
                done_next      = 1'b1;
                kind_next      = KIND_STATUS;
                overt_next     = '0;
                oref_next      = '0;
                state_next     = S_IDLE;
            end
            S_RREF:
            begin
                v_next     = ord_rd_reg;
                ref_ra     = ord_rd_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The read result is registered once the reference fetch has returned, flagged by rd_out_reg.
    logic rd_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vcount_reg     <= '0;
            edge_count_reg <= '0;
            order_len_reg  <= '0;
            fell_reg       <= 1'b0;
            rst_cnt_reg    <= '0;
            cur_reg        <= '0;
            nxt_reg        <= '0;
            done_reg       <= 1'b0;
            rd_out_reg     <= 1'b0;
            kind_reg       <= KIND_STATUS;
            overt_reg      <= '0;
            oref_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            vcount_reg     <= vcount_next;
            edge_count_reg <= edge_count_next;
            order_len_reg  <= order_len_next;
            fell_reg       <= fell_next;
            rst_cnt_reg    <= rst_cnt_next;
            cur_reg        <= cur_next;
            nxt_reg        <= nxt_next;
            rd_out_reg     <= (state_reg == S_RREF);
            if (rd_out_reg)
            begin
                done_reg  <= 1'b1;
                kind_reg  <= KIND_READ;
                overt_reg <= hit_reg ? OVERT_W'(v_reg) : '0;
                oref_reg  <= hit_reg ? ref_rd_reg : '0;
            end
            else
            begin
                done_reg  <= done_next;
                kind_reg  <= kind_next;
                overt_reg <= overt_next;
                oref_reg  <= oref_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        root_reg <= root_next;
        v_reg    <= v_next;
        i_reg    <= i_next;
        b_reg    <= b_next;
        w_reg    <= w_next;
        hit_reg  <= hit_next;
    end

    assign busy            = (state_reg != S_IDLE) || rd_out_reg;
    assign done            = done_reg;
    assign kind            = kind_reg;
    assign ordered_vertex  = overt_reg;
    assign ordered_ref     = oref_reg;
    assign start_fell_back = fell_reg;
    assign restarts        = rst_cnt_reg;

    // Assertions
    a_run_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action == ACT_RUN |=> busy)
        else $error("run item did not start the sequencer");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a preceding busy cycle");

    a_nxt_below_cur: assert property (@(posedge clk) disable iff (!rst_n)
        nxt_reg <= cur_reg)
        else $error("fill pointer passed the walk pointer");

endmodule

`default_nettype wire
